[rtl/reproj_pkg.sv]
// Shared types, latencies and fixed-point constants for the reprojection residual pipeline.
`default_nettype none

package reproj_pkg;

  typedef logic signed [63:0] word_t;

  // Unit latencies in register stages
  localparam int FMUL_LAT = 5;
  localparam int DIV_LAT  = 66;
  localparam int SQRT_LAT = 32;
  localparam int CDIV_LAT = 3;

  // Saturation bound of every reproj_fmul product and reproj_div quotient
  localparam logic [63:0] LIM = 64'h0FFF_FFFF_FFFF_FFFF;

  // Q30 angle constants
  localparam word_t       ONE30      = 64'sh0000_0000_4000_0000;
  localparam logic [32:0] PI30       = 33'd3373259426;
  localparam logic [32:0] HALF_PI30  = 33'd1686629713;
  localparam logic [33:0] TWO_PI30   = 34'd6746518852;
  localparam logic [33:0] FOUR_PI30  = 34'd13493037704;

  // theta^2 below this (Q56) takes the cross-product path
  localparam logic [63:0] SMALL_THETA2 = 64'h0000_0000_0100_0000;

  function automatic logic [63:0] mag64(word_t v);
    return v[63] ? 64'(64'd0 - v) : 64'(v);
  endfunction

  function automatic word_t sx32(logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

endpackage

`default_nettype wire

[rtl/reproj_delay.sv]
// Enable-gated shift-register delay line for pipeline alignment.
`default_nettype none

module reproj_delay #(
  parameter int W = 64,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sr_r [N];

  // shift one place per advancing cycle
  always_ff @(posedge clk) begin
    if (en) begin
      sr_r[0] <= d;
      for (int i = 1; i < N; i++) begin
        sr_r[i] <= sr_r[i-1];
      end
    end
  end

  assign q = sr_r[N-1];

endmodule

`default_nettype wire

[rtl/reproj_fmul.sv]
// Pipelined signed 64x64 multiply, truncating shift by SH and saturation to +-LIM.
`default_nettype none

module reproj_fmul #(
  parameter int SH = 16
) (
  input  logic                clk,
  input  logic                en,
  input  reproj_pkg::word_t   a,
  input  reproj_pkg::word_t   b,
  output reproj_pkg::word_t   p
);

  import reproj_pkg::*;

  logic [63:0]  ua_r, ub_r;
  logic [63:0]  p00_r, p01_r, p10_r, p11_r;
  logic [63:0]  p00b_r, p11b_r;
  logic [64:0]  mid_r;
  logic [127:0] full_r;
  logic [3:0]   neg_r;
  logic [127:0] shifted;
  logic [59:0]  mag_sat;
  word_t        p_r;

  // stage 1: magnitudes
  always_ff @(posedge clk) begin
    if (en) begin
      ua_r     <= mag64(a);
      ub_r     <= mag64(b);
      neg_r[0] <= a[63] ^ b[63];
    end
  end

  // stage 2: 32x32 partial products
  always_ff @(posedge clk) begin
    if (en) begin
      p00_r    <= 64'(ua_r[31:0]) * 64'(ub_r[31:0]);
      p01_r    <= 64'(ua_r[31:0]) * 64'(ub_r[63:32]);
      p10_r    <= 64'(ua_r[63:32]) * 64'(ub_r[31:0]);
      p11_r    <= 64'(ua_r[63:32]) * 64'(ub_r[63:32]);
      neg_r[1] <= neg_r[0];
    end
  end

  // stage 3: middle terms
  always_ff @(posedge clk) begin
    if (en) begin
      mid_r    <= 65'(p01_r) + 65'(p10_r);
      p00b_r   <= p00_r;
      p11b_r   <= p11_r;
      neg_r[2] <= neg_r[1];
    end
  end

  // stage 4: full 128-bit product
  always_ff @(posedge clk) begin
    if (en) begin
      full_r   <= {p11b_r, p00b_r} + {31'd0, mid_r, 32'd0};
      neg_r[3] <= neg_r[2];
    end
  end

  // stage 5: rescale, saturate, restore sign
  assign shifted = full_r >> SH;
  assign mag_sat = (|shifted[127:60]) ? LIM[59:0] : shifted[59:0];

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= neg_r[3] ? -word_t'({4'd0, mag_sat}) : word_t'({4'd0, mag_sat});
    end
  end

  assign p = p_r;

endmodule

`default_nettype wire

[rtl/reproj_div.sv]
// Pipelined signed divide (a << SH) / b, one quotient bit per stage, truncated and saturated.
`default_nettype none

module reproj_div #(
  parameter int SH = 16
) (
  input  logic                clk,
  input  logic                en,
  input  reproj_pkg::word_t   a,
  input  reproj_pkg::word_t   b,
  output reproj_pkg::word_t   q
);

  import reproj_pkg::*;

  localparam logic [63:0] CAP = (64'd1 << (63 - SH)) - 64'd1;

  logic [63:0] n_r   [65];
  logic [63:0] d_r   [65];
  logic [63:0] rem_r [65];
  logic [63:0] q_r   [65];
  logic        neg_r [65];
  logic [63:0] ua;
  logic [63:0] ua_cap;
  logic [63:0] q_sat;
  word_t       q_out_r;

  // prep: capped, shifted dividend magnitude and divisor magnitude
  assign ua     = mag64(a);
  assign ua_cap = (ua > CAP) ? CAP : ua;

  always_ff @(posedge clk) begin
    if (en) begin
      n_r[0]   <= ua_cap << SH;
      d_r[0]   <= mag64(b);
      rem_r[0] <= '0;
      q_r[0]   <= '0;
      neg_r[0] <= a[63] ^ b[63];
    end
  end

  // restoring division, one bit a stage
  for (genvar i = 0; i < 64; i++) begin : g_bit
    logic [64:0] trial;
    logic        fit;

    assign trial = {rem_r[i], n_r[i][63]};
    assign fit   = trial >= {1'b0, d_r[i]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i+1] <= fit ? 64'(trial - {1'b0, d_r[i]}) : trial[63:0];
        n_r[i+1]   <= n_r[i] << 1;
        d_r[i+1]   <= d_r[i];
        q_r[i+1]   <= {q_r[i][62:0], fit};
        neg_r[i+1] <= neg_r[i];
      end
    end
  end

  // saturate and restore sign
  assign q_sat = (q_r[64] > LIM) ? LIM : q_r[64];

  always_ff @(posedge clk) begin
    if (en) begin
      q_out_r <= neg_r[64] ? -word_t'(q_sat) : word_t'(q_sat);
    end
  end

  assign q = q_out_r;

endmodule

`default_nettype wire

[rtl/reprojection_residual.sv]
// Top level: fully pipelined fixed-point reprojection residual of one observation per beat.
//
// Input beat on in_*: world point, camera translation, angle-axis rotation, focal length,
// k1/k2 distortion and the observed pixel, packed in in_tdata. Output beat on out_*:
// residual_x and residual_y in out_tdata, bad_depth in out_tuser.
// One beat is taken every cycle while the output is not held. The depth is set by the
// chain square root (32 stages), eight Taylor steps of sin/cos (9 stages each) and the
// projection quotient unit (66 stages), with 5-stage multipliers in between; the quotient
// unit for the unit axis (66 stages) runs beside the sin/cos steps.
// The whole pipeline advances on one enable; valid bits travel with the data. When the
// result register holds a beat that out_tready does not take, the pipeline and in_tready
// hold, so no beat is dropped or repeated. Otherwise a new beat enters while results
// leave. Reset clears the valid bits only; the datapath needs none.
`default_nettype none

module reprojection_residual #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // point_x, point_y, point_z, cam_tx, cam_ty, cam_tz, axis_x, axis_y, axis_z, focal,
  // distortion_pair, observed_pixel
  input  logic [447:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // residual_x, residual_y
  output logic [63:0]  out_tdata,
  // bad_depth
  output logic         out_tuser
);

  import reproj_pkg::*;

  // stage schedule
  localparam int T_SQ  = 3;
  localparam int T_TH  = T_SQ + SQRT_LAT;
  localparam int T_X   = T_TH + 3;
  localparam int T_X2  = T_X + FMUL_LAT;
  localparam int ITER  = FMUL_LAT + CDIV_LAT + 1;
  localparam int T_SC0 = T_X2 + 8 * ITER;
  localparam int T_SN  = T_SC0 + FMUL_LAT;
  localparam int T_SC  = T_SN + 1;
  localparam int T_W   = T_TH + DIV_LAT;
  localparam int T_CR  = T_W + FMUL_LAT + 1;
  localparam int T_OM  = T_SC + 1;
  localparam int T_PJ  = T_OM + FMUL_LAT;
  localparam int T_RT  = T_SC + FMUL_LAT;
  localparam int T_RB  = T_PJ + FMUL_LAT + 1;
  localparam int T_SM  = FMUL_LAT + 1;
  localparam int T_R   = T_RB + 1;
  localparam int T_NR  = T_R + 1;
  localparam int T_D   = T_NR + DIV_LAT;
  localparam int T_Q   = T_D + FMUL_LAT;
  localparam int T_R2  = T_Q + 1;
  localparam int T_R4  = T_R2 + FMUL_LAT;
  localparam int T_K   = T_R4 + FMUL_LAT;
  localparam int T_DI  = T_K + 1;
  localparam int T_PX  = T_DI + FMUL_LAT;
  localparam int T_OUT = T_PX + 1;

  localparam word_t ONE_F = word_t'(64'd1 << FRAC_BITS);

  // ---------------------------------------------------------------- control
  logic              en;
  logic [T_OUT:1]    vld_r;

  assign en         = !vld_r[T_OUT] || out_tready;
  assign in_tready  = en;
  assign out_tvalid = vld_r[T_OUT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[T_OUT-1:1], in_tvalid};
    end
  end

  // ---------------------------------------------------------------- fields
  word_t p_in [3];
  word_t t_in [3];
  word_t a_in [3];
  word_t f_in, k1_in, k2_in;
  logic [63:0] obs_in;

  for (genvar i = 0; i < 3; i++) begin : g_fields
    assign p_in[i] = sx32(in_tdata[32*i +: 32]);
    assign t_in[i] = sx32(in_tdata[96 + 32*i +: 32]);
    assign a_in[i] = sx32(in_tdata[192 + 32*i +: 32]);
  end
  assign f_in   = word_t'({32'd0, in_tdata[319:288]});
  assign k1_in  = sx32(in_tdata[383:352]);
  assign k2_in  = sx32(in_tdata[351:320]);
  assign obs_in = in_tdata[447:384];

  // ---------------------------------------------------------------- theta^2
  logic [31:0] am_r [3];
  logic [63:0] sq_r [3];
  logic [63:0] th2_r;
  logic [63:0] th2_sum;
  logic        sml_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        am_r[i] <= a_in[i][31] ? 32'(32'd0 - a_in[i][31:0]) : a_in[i][31:0];
        sq_r[i] <= 64'(am_r[i]) * 64'(am_r[i]);
      end
    end
  end

  assign th2_sum = sq_r[0] + sq_r[1] + sq_r[2];

  always_ff @(posedge clk) begin
    if (en) begin
      th2_r <= th2_sum;
      sml_r <= th2_sum < SMALL_THETA2;
    end
  end

  // ---------------------------------------------------------------- square root
  logic [63:0] sv_r [SQRT_LAT];
  logic [63:0] sr_r [SQRT_LAT];

  for (genvar i = 0; i < SQRT_LAT; i++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
    logic [63:0] v_in, r_in, trial;

    if (i == 0) begin : g_first
      assign v_in = th2_r;
      assign r_in = '0;
    end else begin : g_next
      assign v_in = sv_r[i-1];
      assign r_in = sr_r[i-1];
    end

    assign trial = r_in + BIT;

    always_ff @(posedge clk) begin
      if (en) begin
        if (v_in >= trial) begin
          sv_r[i] <= v_in - trial;
          sr_r[i] <= (r_in >> 1) + BIT;
        end else begin
          sv_r[i] <= v_in;
          sr_r[i] <= r_in >> 1;
        end
      end
    end
  end

  logic [31:0] theta;
  assign theta = sr_r[SQRT_LAT-1][31:0];

  // ---------------------------------------------------------------- angle reduction
  logic [33:0] ang;
  logic [32:0] xm_r, xf_r;
  logic [31:0] xx_r;
  logic        ns1_r, nc1_r, ns2_r, nc2_r;

  assign ang = {theta, 2'b00};

  always_ff @(posedge clk) begin
    if (en) begin
      // modulo 2*pi, quotient at most two
      if (ang >= FOUR_PI30) begin
        xm_r <= 33'(ang - FOUR_PI30);
      end else if (ang >= TWO_PI30) begin
        xm_r <= 33'(ang - TWO_PI30);
      end else begin
        xm_r <= ang[32:0];
      end
      // fold into [0, pi)
      if (xm_r >= PI30) begin
        xf_r  <= xm_r - PI30;
        ns1_r <= 1'b1;
        nc1_r <= 1'b1;
      end else begin
        xf_r  <= xm_r;
        ns1_r <= 1'b0;
        nc1_r <= 1'b0;
      end
      // fold into [0, pi/2]
      if (xf_r > HALF_PI30) begin
        xx_r  <= 32'(PI30 - xf_r);
        nc2_r <= !nc1_r;
      end else begin
        xx_r  <= xf_r[31:0];
        nc2_r <= nc1_r;
      end
      ns2_r <= ns1_r;
    end
  end

  // ---------------------------------------------------------------- sin / cos series
  word_t xx_w, x2_w [8];
  word_t scw [9][2];

  assign xx_w = word_t'({32'd0, xx_r});

  reproj_fmul #(.SH(30)) u_x2 (.clk(clk), .en(en), .a(xx_w), .b(xx_w), .p(x2_w[0]));

  assign scw[0][0] = ONE30;
  assign scw[0][1] = ONE30;

  for (genvar k = 0; k < 8; k++) begin : g_term
    if (k < 7) begin : g_x2d
      reproj_delay #(.W(64), .N(ITER)) u_x2d (
        .clk(clk), .en(en), .d(x2_w[k]), .q(x2_w[k+1])
      );
    end

    // j = 0: sin chain, j = 1: cos chain
    for (genvar j = 0; j < 2; j++) begin : g_chain
      localparam int          NN = 8 - k;
      localparam int          DV = (2 * NN - j) * (2 * NN + 1 - j);
      localparam logic [31:0] RC = 32'(64'h1_0000_0000 / DV);

      word_t       mp;
      logic [63:0] prod;
      logic [31:0] va_r, q0_r, q0b_r, qq_r;
      logic [15:0] rem_r;
      logic [40:0] qd;
      word_t       sc_r;

      reproj_fmul #(.SH(30)) u_m (
        .clk(clk), .en(en), .a(x2_w[k]), .b(scw[k][j]), .p(mp)
      );

      // quotient by a constant: reciprocal estimate, then one correction
      assign prod = 64'(mp[31:0]) * 64'(RC);
      assign qd   = 41'(q0_r) * 41'(DV);

      always_ff @(posedge clk) begin
        if (en) begin
          va_r  <= mp[31:0];
          q0_r  <= prod[63:32];
          rem_r <= 16'(41'(va_r) - qd);
          q0b_r <= q0_r;
          qq_r  <= q0b_r + ((rem_r >= 16'(DV)) ? 32'd1 : 32'd0);
          sc_r  <= ONE30 - word_t'({32'd0, qq_r});
        end
      end

      assign scw[k+1][j] = sc_r;
    end
  end

  word_t xx_d, sn_raw, cs_raw;
  logic [1:0] nflag_d;
  word_t sn_r, cs_r;

  reproj_delay #(.W(64), .N(T_SC0 - T_X)) u_xxd (
    .clk(clk), .en(en), .d(xx_w), .q(xx_d)
  );
  reproj_fmul #(.SH(30)) u_sn (.clk(clk), .en(en), .a(xx_d), .b(scw[8][0]), .p(sn_raw));
  reproj_delay #(.W(64), .N(FMUL_LAT)) u_csd (
    .clk(clk), .en(en), .d(scw[8][1]), .q(cs_raw)
  );
  reproj_delay #(.W(2), .N(T_SN - T_X)) u_nfd (
    .clk(clk), .en(en), .d({nc2_r, ns2_r}), .q(nflag_d)
  );

  // quadrant signs
  always_ff @(posedge clk) begin
    if (en) begin
      sn_r <= nflag_d[0] ? -sn_raw : sn_raw;
      cs_r <= nflag_d[1] ? -cs_raw : cs_raw;
    end
  end

  // ---------------------------------------------------------------- unit axis
  word_t a_d [3];
  word_t w_w [3];
  word_t theta_w;
  word_t p_d5 [3];
  word_t p_dw [3];
  word_t p_dc [3];

  assign theta_w = word_t'({32'd0, theta});

  for (genvar i = 0; i < 3; i++) begin : g_axis
    reproj_delay #(.W(64), .N(T_TH)) u_ad (.clk(clk), .en(en), .d(a_in[i]), .q(a_d[i]));
    reproj_div #(.SH(30)) u_w (.clk(clk), .en(en), .a(a_d[i]), .b(theta_w), .q(w_w[i]));
    reproj_delay #(.W(64), .N(FMUL_LAT)) u_p5 (
      .clk(clk), .en(en), .d(p_in[i]), .q(p_d5[i])
    );
    reproj_delay #(.W(64), .N(T_W - FMUL_LAT)) u_pw (
      .clk(clk), .en(en), .d(p_d5[i]), .q(p_dw[i])
    );
    reproj_delay #(.W(64), .N(T_SC - T_W)) u_pc (
      .clk(clk), .en(en), .d(p_dw[i]), .q(p_dc[i])
    );
  end

  // ---------------------------------------------------------------- cross and dot
  // cm[2*i] and cm[2*i+1] are the two cross terms of component i
  word_t cm [6];
  word_t dm [3];
  word_t cr_r [3];
  word_t dot_r;

  reproj_fmul #(.SH(30)) u_c0 (.clk(clk), .en(en), .a(w_w[1]), .b(p_dw[2]), .p(cm[0]));
  reproj_fmul #(.SH(30)) u_c1 (.clk(clk), .en(en), .a(w_w[2]), .b(p_dw[1]), .p(cm[1]));
  reproj_fmul #(.SH(30)) u_c2 (.clk(clk), .en(en), .a(w_w[2]), .b(p_dw[0]), .p(cm[2]));
  reproj_fmul #(.SH(30)) u_c3 (.clk(clk), .en(en), .a(w_w[0]), .b(p_dw[2]), .p(cm[3]));
  reproj_fmul #(.SH(30)) u_c4 (.clk(clk), .en(en), .a(w_w[0]), .b(p_dw[1]), .p(cm[4]));
  reproj_fmul #(.SH(30)) u_c5 (.clk(clk), .en(en), .a(w_w[1]), .b(p_dw[0]), .p(cm[5]));

  for (genvar i = 0; i < 3; i++) begin : g_dot
    reproj_fmul #(.SH(30)) u_d (.clk(clk), .en(en), .a(w_w[i]), .b(p_dw[i]), .p(dm[i]));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        cr_r[i] <= cm[2*i] - cm[2*i+1];
      end
      dot_r <= dm[0] + dm[1] + dm[2];
    end
  end

  // ---------------------------------------------------------------- Rodrigues sum
  word_t om_r, dot_d, proj;
  word_t cr_d [3];
  word_t w_d  [3];
  word_t rt1 [3];
  word_t rt2 [3];
  word_t rt3 [3];
  word_t rt1_d [3];
  word_t rt2_d [3];
  word_t rb_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      om_r <= ONE30 - cs_r;
    end
  end

  reproj_delay #(.W(64), .N(T_OM - T_CR)) u_dotd (
    .clk(clk), .en(en), .d(dot_r), .q(dot_d)
  );
  reproj_fmul #(.SH(30)) u_proj (.clk(clk), .en(en), .a(dot_d), .b(om_r), .p(proj));

  for (genvar i = 0; i < 3; i++) begin : g_rod
    reproj_delay #(.W(64), .N(T_SC - T_CR)) u_crd (
      .clk(clk), .en(en), .d(cr_r[i]), .q(cr_d[i])
    );
    reproj_delay #(.W(64), .N(T_PJ - T_W)) u_wd (
      .clk(clk), .en(en), .d(w_w[i]), .q(w_d[i])
    );
    reproj_fmul #(.SH(30)) u_t1 (.clk(clk), .en(en), .a(p_dc[i]), .b(cs_r), .p(rt1[i]));
    reproj_fmul #(.SH(30)) u_t2 (.clk(clk), .en(en), .a(cr_d[i]), .b(sn_r), .p(rt2[i]));
    reproj_fmul #(.SH(30)) u_t3 (.clk(clk), .en(en), .a(w_d[i]), .b(proj), .p(rt3[i]));
    reproj_delay #(.W(64), .N(T_PJ + FMUL_LAT - T_RT)) u_t1d (
      .clk(clk), .en(en), .d(rt1[i]), .q(rt1_d[i])
    );
    reproj_delay #(.W(64), .N(T_PJ + FMUL_LAT - T_RT)) u_t2d (
      .clk(clk), .en(en), .d(rt2[i]), .q(rt2_d[i])
    );

    always_ff @(posedge clk) begin
      if (en) begin
        rb_r[i] <= rt1_d[i] + rt2_d[i] + rt3[i];
      end
    end
  end

  // ---------------------------------------------------------------- small-angle path
  word_t sm [6];
  word_t rs_r [3];
  word_t rs_d [3];

  reproj_fmul #(.SH(28)) u_s0 (.clk(clk), .en(en), .a(a_in[1]), .b(p_in[2]), .p(sm[0]));
  reproj_fmul #(.SH(28)) u_s1 (.clk(clk), .en(en), .a(a_in[2]), .b(p_in[1]), .p(sm[1]));
  reproj_fmul #(.SH(28)) u_s2 (.clk(clk), .en(en), .a(a_in[2]), .b(p_in[0]), .p(sm[2]));
  reproj_fmul #(.SH(28)) u_s3 (.clk(clk), .en(en), .a(a_in[0]), .b(p_in[2]), .p(sm[3]));
  reproj_fmul #(.SH(28)) u_s4 (.clk(clk), .en(en), .a(a_in[0]), .b(p_in[1]), .p(sm[4]));
  reproj_fmul #(.SH(28)) u_s5 (.clk(clk), .en(en), .a(a_in[1]), .b(p_in[0]), .p(sm[5]));

  for (genvar i = 0; i < 3; i++) begin : g_small
    always_ff @(posedge clk) begin
      if (en) begin
        rs_r[i] <= p_d5[i] + sm[2*i] - sm[2*i+1];
      end
    end
    reproj_delay #(.W(64), .N(T_RB - T_SM)) u_rsd (
      .clk(clk), .en(en), .d(rs_r[i]), .q(rs_d[i])
    );
  end

  // ---------------------------------------------------------------- translate
  logic  sml_d;
  word_t t_d [3];
  word_t r_r [3];
  word_t nr0_r, nr1_r, rz_r;
  logic  bad_r;

  reproj_delay #(.W(1), .N(T_RB - T_SQ)) u_smld (
    .clk(clk), .en(en), .d(sml_r), .q(sml_d)
  );

  for (genvar i = 0; i < 3; i++) begin : g_trans
    reproj_delay #(.W(64), .N(T_RB)) u_td (.clk(clk), .en(en), .d(t_in[i]), .q(t_d[i]));

    always_ff @(posedge clk) begin
      if (en) begin
        r_r[i] <= (sml_d ? rs_d[i] : rb_r[i]) + t_d[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nr0_r <= -r_r[0];
      nr1_r <= -r_r[1];
      rz_r  <= r_r[2];
      bad_r <= r_r[2] == '0;
    end
  end

  // ---------------------------------------------------------------- projection
  word_t dx, dy, f_d, dxx, dyy, dxf, dyf;
  word_t r2_r, r2_d, r4, k1_d, k2_d, tk1, tk2, dist_r;
  word_t dxf_d, dyf_d, px, py;

  reproj_div #(.SH(FRAC_BITS)) u_dx (.clk(clk), .en(en), .a(nr0_r), .b(rz_r), .q(dx));
  reproj_div #(.SH(FRAC_BITS)) u_dy (.clk(clk), .en(en), .a(nr1_r), .b(rz_r), .q(dy));

  reproj_delay #(.W(64), .N(T_D)) u_fd (.clk(clk), .en(en), .d(f_in), .q(f_d));

  reproj_fmul #(.SH(FRAC_BITS)) u_dxx (.clk(clk), .en(en), .a(dx), .b(dx), .p(dxx));
  reproj_fmul #(.SH(FRAC_BITS)) u_dyy (.clk(clk), .en(en), .a(dy), .b(dy), .p(dyy));
  reproj_fmul #(.SH(FRAC_BITS)) u_dxf (.clk(clk), .en(en), .a(dx), .b(f_d), .p(dxf));
  reproj_fmul #(.SH(FRAC_BITS)) u_dyf (.clk(clk), .en(en), .a(dy), .b(f_d), .p(dyf));

  always_ff @(posedge clk) begin
    if (en) begin
      r2_r <= dxx + dyy;
    end
  end

  reproj_fmul #(.SH(FRAC_BITS)) u_r4 (.clk(clk), .en(en), .a(r2_r), .b(r2_r), .p(r4));
  reproj_delay #(.W(64), .N(FMUL_LAT)) u_r2d (.clk(clk), .en(en), .d(r2_r), .q(r2_d));
  reproj_delay #(.W(64), .N(T_R4)) u_k1d (.clk(clk), .en(en), .d(k1_in), .q(k1_d));
  reproj_delay #(.W(64), .N(T_R4)) u_k2d (.clk(clk), .en(en), .d(k2_in), .q(k2_d));
  reproj_fmul #(.SH(28)) u_tk1 (.clk(clk), .en(en), .a(r2_d), .b(k1_d), .p(tk1));
  reproj_fmul #(.SH(28)) u_tk2 (.clk(clk), .en(en), .a(r4), .b(k2_d), .p(tk2));

  // radial distortion factor
  always_ff @(posedge clk) begin
    if (en) begin
      dist_r <= ONE_F + tk1 + tk2;
    end
  end

  reproj_delay #(.W(64), .N(T_DI - T_Q)) u_dxfd (.clk(clk), .en(en), .d(dxf), .q(dxf_d));
  reproj_delay #(.W(64), .N(T_DI - T_Q)) u_dyfd (.clk(clk), .en(en), .d(dyf), .q(dyf_d));
  reproj_fmul #(.SH(FRAC_BITS)) u_px (.clk(clk), .en(en), .a(dxf_d), .b(dist_r), .p(px));
  reproj_fmul #(.SH(FRAC_BITS)) u_py (.clk(clk), .en(en), .a(dyf_d), .b(dist_r), .p(py));

  // ---------------------------------------------------------------- residual and output
  logic [63:0] obs_d;
  logic        bad_d;
  word_t       ex, ey;
  logic [31:0] res_x, res_y;
  logic [63:0] out_tdata_r;
  logic        out_tuser_r;

  reproj_delay #(.W(64), .N(T_PX)) u_obsd (.clk(clk), .en(en), .d(obs_in), .q(obs_d));
  reproj_delay #(.W(1), .N(T_PX - T_NR)) u_badd (.clk(clk), .en(en), .d(bad_r), .q(bad_d));

  assign ex = px - sx32(obs_d[63:32]);
  assign ey = py - sx32(obs_d[31:0]);

  always_comb begin
    if (ex > 64'sh0000_0000_7FFF_FFFF) begin
      res_x = 32'h7FFF_FFFF;
    end else if (ex < -64'sh0000_0000_8000_0000) begin
      res_x = 32'h8000_0000;
    end else begin
      res_x = ex[31:0];
    end
    if (ey > 64'sh0000_0000_7FFF_FFFF) begin
      res_y = 32'h7FFF_FFFF;
    end else if (ey < -64'sh0000_0000_8000_0000) begin
      res_y = 32'h8000_0000;
    end else begin
      res_y = ey[31:0];
    end
  end

  // zero depth forces both residuals to the positive limit
  always_ff @(posedge clk) begin
    if (en) begin
      if (bad_d) begin
        out_tdata_r <= {32'h7FFF_FFFF, 32'h7FFF_FFFF};
      end else begin
        out_tdata_r <= {res_y, res_x};
      end
      out_tuser_r <= bad_d;
    end
  end

  assign out_tdata = out_tdata_r;
  assign out_tuser = out_tuser_r;

endmodule

`default_nettype wire

[verif/tb_reprojection_residual.sv]
// Stream testbench for the reprojection residual pipeline, with its own bit-exact predictor.
`timescale 1ns / 1ps

module tb_reprojection_residual;

  typedef logic signed [63:0] s64_t;
  typedef logic [63:0]        u64_t;

  typedef struct packed {
    logic [31:0] res_x;
    logic [31:0] res_y;
    logic        bad_depth;
  } residual_t;

  localparam u64_t SAT_LIM    = 64'h0FFF_FFFF_FFFF_FFFF;
  localparam s64_t Q30_ONE    = 64'sd1073741824;
  localparam s64_t Q30_PI     = 64'sd3373259426;
  localparam s64_t Q30_HPI    = 64'sd1686629713;
  localparam u64_t Q30_TWOPI  = 64'd6746518852;
  localparam u64_t TINY_ANGLE = 64'd16777216;
  localparam int   FB         = 16;
  localparam int   CYCLE_CAP  = 600000;
  localparam int   DRAIN_WAIT = 300;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [447:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [63:0]  out_tdata;
  logic         out_tuser;

  logic [447:0] obs_pending[$];
  residual_t    residual_due[$];
  logic         in_fire = 1'b0;
  logic         no_idle = 1'b0;
  logic         stall_req = 1'b0;
  logic         stall_done = 1'b0;
  int           stall_left = 0;
  int           err_count = 0;
  int           cycles = 0;

  always #1 clk = ~clk;

  reprojection_residual #(.FRAC_BITS(FB)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // ---------------- fixed-point predictor ----------------

  function automatic u64_t magn(s64_t v);
    return v[63] ? u64_t'(64'd0 - u64_t'(v)) : u64_t'(v);
  endfunction

  // product rescaled by sh, magnitude truncated, saturated
  function automatic s64_t qmul(s64_t a, s64_t b, int sh);
    logic [127:0] prod;
    u64_t r;
    prod = {64'd0, magn(a)} * {64'd0, magn(b)};
    if ((prod[127:64] >> sh) != 0) r = SAT_LIM;
    else r = u64_t'(prod >> sh);
    if (r > SAT_LIM) r = SAT_LIM;
    return (a[63] ^ b[63]) ? s64_t'(64'd0 - r) : s64_t'(r);
  endfunction

  // (a << sh) / b, truncated, saturated
  function automatic s64_t qdiv(s64_t a, s64_t b, int sh);
    u64_t ua, cap, q;
    ua = magn(a);
    cap = (64'd1 << (63 - sh)) - 64'd1;
    if (ua > cap) ua = cap;
    q = (ua << sh) / magn(b);
    if (q > SAT_LIM) q = SAT_LIM;
    return (a[63] ^ b[63]) ? s64_t'(64'd0 - q) : s64_t'(q);
  endfunction

  function automatic u64_t int_sqrt(u64_t v);
    u64_t res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // theta Q28 -> sin, cos Q30
  function automatic void sin_cos(u64_t theta, output s64_t sn, output s64_t cs);
    s64_t x, x2, s, c;
    logic neg_s, neg_c;
    longint k;
    x = s64_t'((theta << 2) % Q30_TWOPI);
    s = Q30_ONE;
    c = Q30_ONE;
    neg_s = 1'b0;
    neg_c = 1'b0;
    if (x >= Q30_PI) begin
      x = x - Q30_PI;
      neg_s = 1'b1;
      neg_c = 1'b1;
    end
    if (x > Q30_HPI) begin
      x = Q30_PI - x;
      neg_c = ~neg_c;
    end
    x2 = qmul(x, x, 30);
    for (int n = 8; n >= 1; n--) begin
      k = (2 * n) * (2 * n + 1);
      s = Q30_ONE - qmul(x2, s, 30) / k;
      k = (2 * n - 1) * (2 * n);
      c = Q30_ONE - qmul(x2, c, 30) / k;
    end
    s = qmul(x, s, 30);
    sn = neg_s ? -s : s;
    cs = neg_c ? -c : c;
  endfunction

  function automatic s64_t clamp32(s64_t v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic s64_t sext(logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  function automatic residual_t residual_of(logic [447:0] d);
    s64_t p[3], t[3], a[3], r[3], w[3], cr[3];
    s64_t k1, k2, obx, oby, f, sn, cs, dot, proj, theta;
    s64_t dx, dy, r2, r4, radial, px, py;
    u64_t theta2;
    residual_t res;
    for (int i = 0; i < 3; i++) begin
      p[i] = sext(d[32*i +: 32]);
      t[i] = sext(d[32*(3+i) +: 32]);
      a[i] = sext(d[32*(6+i) +: 32]);
    end
    f = s64_t'({32'd0, d[319:288]});
    k2 = sext(d[351:320]);
    k1 = sext(d[383:352]);
    oby = sext(d[415:384]);
    obx = sext(d[447:416]);
    theta2 = 0;
    for (int i = 0; i < 3; i++) theta2 = theta2 + magn(a[i]) * magn(a[i]);
    if (theta2 < TINY_ANGLE) begin
      // near-zero rotation: p + a x p
      r[0] = p[0] + qmul(a[1], p[2], 28) - qmul(a[2], p[1], 28);
      r[1] = p[1] + qmul(a[2], p[0], 28) - qmul(a[0], p[2], 28);
      r[2] = p[2] + qmul(a[0], p[1], 28) - qmul(a[1], p[0], 28);
    end else begin
      theta = s64_t'(int_sqrt(theta2));
      sin_cos(u64_t'(theta), sn, cs);
      for (int i = 0; i < 3; i++) w[i] = qdiv(a[i], theta, 30);
      cr[0] = qmul(w[1], p[2], 30) - qmul(w[2], p[1], 30);
      cr[1] = qmul(w[2], p[0], 30) - qmul(w[0], p[2], 30);
      cr[2] = qmul(w[0], p[1], 30) - qmul(w[1], p[0], 30);
      dot = 0;
      for (int i = 0; i < 3; i++) dot = dot + qmul(w[i], p[i], 30);
      proj = qmul(dot, Q30_ONE - cs, 30);
      for (int i = 0; i < 3; i++)
        r[i] = qmul(p[i], cs, 30) + qmul(cr[i], sn, 30) + qmul(w[i], proj, 30);
    end
    for (int i = 0; i < 3; i++) r[i] = r[i] + t[i];
    if (r[2] == 0) begin
      res.res_x = 32'h7FFF_FFFF;
      res.res_y = 32'h7FFF_FFFF;
      res.bad_depth = 1'b1;
      return res;
    end
    dx = qdiv(-r[0], r[2], FB);
    dy = qdiv(-r[1], r[2], FB);
    r2 = qmul(dx, dx, FB) + qmul(dy, dy, FB);
    r4 = qmul(r2, r2, FB);
    radial = (s64_t'(1) <<< FB) + qmul(r2, k1, 28) + qmul(r4, k2, 28);
    px = qmul(qmul(dx, f, FB), radial, FB);
    py = qmul(qmul(dy, f, FB), radial, FB);
    res.res_x = 32'(clamp32(px - obx));
    res.res_y = 32'(clamp32(py - oby));
    res.bad_depth = 1'b0;
    return res;
  endfunction

  // ---------------- stimulus helpers ----------------

  function automatic logic [447:0] pack_obs(
    logic [31:0] px, py, pz, tx, ty, tz, ax, ay, az, f, k1, k2, ox, oy);
    return {ox, oy, k1, k2, f, az, ay, ax, tz, ty, tx, pz, py, px};
  endfunction

  function automatic logic [31:0] spread(int m);
    return 32'($urandom_range(0, 2 * m) - m);
  endfunction

  // plausible camera and point, random content
  function automatic logic [447:0] plausible_obs();
    logic [31:0] ax, ay, az;
    ax = spread(100000000);
    ay = spread(100000000);
    az = spread(100000000);
    if ($urandom_range(0, 4) == 0) begin
      ax = spread(3000);
      ay = spread(3000);
      az = spread(3000);
    end
    return pack_obs(spread(30 << 16), spread(30 << 16), spread(30 << 16),
                    spread(5 << 16), spread(5 << 16), spread(60 << 16),
                    ax, ay, az, 32'($urandom_range(100 << 16, 2000 << 16)),
                    spread(1 << 26), spread(1 << 24),
                    spread(800 << 16), spread(800 << 16));
  endfunction

  function automatic logic [447:0] noise_obs();
    return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
            $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
  endfunction

  // append one beat to the pending queue
  task automatic enqueue_obs(input logic [447:0] d);
    obs_pending = {obs_pending, d};
  endtask

  // ---------------- driver ----------------

  always @(posedge clk) in_fire <= rst_n && in_tvalid && in_tready;

  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_fire)) begin
      if (obs_pending.size() != 0 && (no_idle || $urandom_range(0, 99) >= 24)) begin
        in_tdata  <= obs_pending.pop_front();
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver, with one long hold-off
  always @(negedge clk) begin
    if (stall_req && !stall_done) begin
      stall_done <= 1'b1;
      stall_left <= 900;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= no_idle || ($urandom_range(0, 99) >= 24);
    end
  end

  // ---------------- monitor ----------------

  always @(posedge clk) begin
    residual_t got, want;
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("tb_reprojection_residual: done, errors");
      $finish;
    end else if (rst_n) begin
      if (in_tvalid && in_tready) residual_due = {residual_due, residual_of(in_tdata)};
      if (out_tvalid && out_tready) begin
        got.res_x = out_tdata[31:0];
        got.res_y = out_tdata[63:32];
        got.bad_depth = out_tuser;
        if (residual_due.size() == 0) begin
          $error("unexpected result beat: residual_x %h", got.res_x);
          err_count = err_count + 1;
        end else begin
          want = residual_due.pop_front();
          if (got.res_x !== want.res_x) begin
            $error("residual_x: expected %h, got %h", want.res_x, got.res_x);
            err_count = err_count + 1;
          end
          if (got.res_y !== want.res_y) begin
            $error("residual_y: expected %h, got %h", want.res_y, got.res_y);
            err_count = err_count + 1;
          end
          if (got.bad_depth !== want.bad_depth) begin
            $error("bad_depth: expected %b, got %b", want.bad_depth, got.bad_depth);
            err_count = err_count + 1;
          end
        end
      end
    end
  end

  // ---------------- sequence ----------------

  task automatic wait_drained();
    while (obs_pending.size() != 0 || in_tvalid || residual_due.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);

    // directed: zero depth everywhere, extremes, angle edge cases
    enqueue_obs('0);
    enqueue_obs({448{1'b1}});
    enqueue_obs({14{32'h8000_0000}});
    enqueue_obs({14{32'h7FFF_FFFF}});
    // depth cancels exactly through translation
    enqueue_obs(pack_obs(32'h0001_0000, 32'h0002_0000, 32'h0005_0000, 0, 0,
                          32'hFFFB_0000, 0, 0, 0, 32'h01F4_0000, 0, 0, 0, 0));
    // tiny angles: one just above the cross-product threshold, one exactly at it
    enqueue_obs(pack_obs(32'h0001_0000, 32'h0002_0000, 32'hFFF6_0000, 0, 0, 0,
                          32'd4095, 32'hFFFF_F001, 32'd100, 32'h01F4_0000, 0, 0, 0, 0));
    enqueue_obs(pack_obs(32'h0001_0000, 32'h0002_0000, 32'hFFF6_0000, 0, 0, 0,
                          32'd4096, 0, 0, 32'h01F4_0000, 0, 0, 0, 0));
    // half turn, quarter turn, large angles reduced mod 2 pi
    enqueue_obs(pack_obs(32'h0001_0000, 32'h0002_0000, 32'hFFF6_0000, 0, 0, 0,
                          32'd843314857, 0, 0, 32'h01F4_0000, 0, 0, 0, 0));
    enqueue_obs(pack_obs(32'h0003_0000, 32'hFFFE_0000, 32'h0007_0000, 0, 0, 0,
                          0, 32'd421657428, 0, 32'h01F4_0000, 0, 0, 0, 0));
    enqueue_obs(pack_obs(32'h0003_0000, 32'hFFFE_0000, 32'h0007_0000, 0, 0, 0,
                          32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h01F4_0000,
                          0, 0, 0, 0));
    // saturating residuals through huge focal and distortion, then zero focal with extreme distortion
    enqueue_obs(pack_obs(32'h7FFF_0000, 32'h8000_0000, 32'h0000_0001, 0, 0, 0,
                          0, 0, 0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                          32'h8000_0000, 32'h7FFF_FFFF));
    enqueue_obs(pack_obs(32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000, 0, 0, 0,
                          0, 0, 0, 0, 32'h8000_0000, 32'h8000_0000, 0, 0));
    for (int i = 0; i < 8; i++) enqueue_obs(plausible_obs());
    wait_drained();

    // random phase with one long receiver hold-off that backs the pipe up
    for (int i = 0; i < 500; i++)
      enqueue_obs($urandom_range(0, 3) == 0 ? noise_obs() : plausible_obs());
    @(posedge clk);
    stall_req = 1'b1;
    wait_drained();

    // no idling on either side
    no_idle = 1'b1;
    for (int i = 0; i < 300; i++)
      enqueue_obs($urandom_range(0, 3) == 0 ? noise_obs() : plausible_obs());
    wait_drained();
    no_idle = 1'b0;

    for (int i = 0; i < 400; i++)
      enqueue_obs($urandom_range(0, 3) == 0 ? noise_obs() : plausible_obs());
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);

    if (err_count == 0 && residual_due.size() == 0) begin
      $display("tb_reprojection_residual: done, clean");
    end else begin
      if (residual_due.size() != 0) $error("results missing: %0d", residual_due.size());
      $display("tb_reprojection_residual: done, errors");
    end
    $finish;
  end

endmodule

[files.f]
rtl/reproj_pkg.sv
rtl/reproj_delay.sv
rtl/reproj_fmul.sv
rtl/reproj_div.sv
rtl/reprojection_residual.sv
verif/tb_reprojection_residual.sv
